FILE: hw/rtl/pvs_pkg.sv
package pvs_pkg;

  localparam int RES_W  = 32;
  localparam int SER_W  = 8;
  localparam int HUND_W = 10;
  localparam int EXP_W  = 4;

  // table memory: e192 entries first, then the e24 entries
  localparam int TBL_DEPTH  = 216;
  localparam int TBL_ADDR_W = 8;
  localparam int E24_LEN    = 24;
  localparam int E192_LEN   = 192;
  localparam logic [TBL_ADDR_W-1:0] E192_BASE = 8'd0;
  localparam logic [TBL_ADDR_W-1:0] E24_BASE  = 8'd192;
  localparam logic [TBL_ADDR_W-1:0] TBL_LAST  = 8'd215;

  localparam int STRIDE_W = 5;

  localparam logic [SER_W-1:0] SER_E1   = 8'd1;
  localparam logic [SER_W-1:0] SER_E3   = 8'd3;
  localparam logic [SER_W-1:0] SER_E6   = 8'd6;
  localparam logic [SER_W-1:0] SER_E12  = 8'd12;
  localparam logic [SER_W-1:0] SER_E24  = 8'd24;
  localparam logic [SER_W-1:0] SER_E48  = 8'd48;
  localparam logic [SER_W-1:0] SER_E96  = 8'd96;
  localparam logic [SER_W-1:0] SER_E192 = 8'd192;

  localparam logic [HUND_W-1:0] HUND_MIN = 10'd100;
  localparam logic [HUND_W-1:0] HUND_MAX = 10'd988;
  localparam logic [EXP_W-1:0]  EXP_MAX  = 4'd9;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_DECADE,
    ST_WALK,
    ST_FINISH
  } state_t;

  localparam logic [HUND_W-1:0] E24_TAB [E24_LEN] = '{
    10'd100, 10'd110, 10'd120, 10'd130, 10'd150, 10'd160, 10'd180, 10'd200,
    10'd220, 10'd240, 10'd270, 10'd300, 10'd330, 10'd360, 10'd390, 10'd430,
    10'd470, 10'd510, 10'd560, 10'd620, 10'd680, 10'd750, 10'd820, 10'd910
  };

  localparam logic [HUND_W-1:0] E192_TAB [E192_LEN] = '{
    10'd100, 10'd101, 10'd102, 10'd104, 10'd105, 10'd106, 10'd107, 10'd109,
    10'd110, 10'd111, 10'd113, 10'd114, 10'd115, 10'd117, 10'd118, 10'd120,
    10'd121, 10'd123, 10'd124, 10'd126, 10'd127, 10'd129, 10'd130, 10'd132,
    10'd133, 10'd135, 10'd137, 10'd138, 10'd140, 10'd142, 10'd143, 10'd145,
    10'd147, 10'd149, 10'd150, 10'd152, 10'd154, 10'd156, 10'd158, 10'd160,
    10'd162, 10'd164, 10'd165, 10'd167, 10'd169, 10'd172, 10'd174, 10'd176,
    10'd178, 10'd180, 10'd182, 10'd184, 10'd187, 10'd189, 10'd191, 10'd193,
    10'd196, 10'd198, 10'd200, 10'd203, 10'd205, 10'd208, 10'd210, 10'd213,
    10'd215, 10'd218, 10'd221, 10'd223, 10'd226, 10'd229, 10'd232, 10'd234,
    10'd237, 10'd240, 10'd243, 10'd246, 10'd249, 10'd252, 10'd255, 10'd258,
    10'd261, 10'd264, 10'd267, 10'd271, 10'd274, 10'd277, 10'd280, 10'd284,
    10'd287, 10'd291, 10'd294, 10'd298, 10'd301, 10'd305, 10'd309, 10'd312,
    10'd316, 10'd320, 10'd324, 10'd328, 10'd332, 10'd336, 10'd340, 10'd344,
    10'd348, 10'd352, 10'd357, 10'd361, 10'd365, 10'd370, 10'd374, 10'd379,
    10'd383, 10'd388, 10'd392, 10'd397, 10'd402, 10'd407, 10'd412, 10'd417,
    10'd422, 10'd427, 10'd432, 10'd437, 10'd442, 10'd448, 10'd453, 10'd459,
    10'd464, 10'd470, 10'd475, 10'd481, 10'd487, 10'd493, 10'd499, 10'd505,
    10'd511, 10'd517, 10'd523, 10'd530, 10'd536, 10'd542, 10'd549, 10'd556,
    10'd562, 10'd569, 10'd576, 10'd583, 10'd590, 10'd597, 10'd604, 10'd612,
    10'd619, 10'd626, 10'd634, 10'd642, 10'd649, 10'd657, 10'd665, 10'd673,
    10'd681, 10'd690, 10'd698, 10'd706, 10'd715, 10'd723, 10'd732, 10'd741,
    10'd750, 10'd759, 10'd768, 10'd777, 10'd787, 10'd796, 10'd806, 10'd816,
    10'd825, 10'd835, 10'd845, 10'd856, 10'd866, 10'd876, 10'd887, 10'd898,
    10'd909, 10'd920, 10'd931, 10'd942, 10'd953, 10'd965, 10'd976, 10'd988
  };

  // contents of the table memory at a given address
  function automatic logic [HUND_W-1:0] tbl_value(input logic [TBL_ADDR_W-1:0] addr);
    logic [TBL_ADDR_W-1:0] off;
    off = addr - E24_BASE;
    if (addr < E24_BASE) begin
      return E192_TAB[addr];
    end else if (addr <= TBL_LAST) begin
      return E24_TAB[off[4:0]];
    end else begin
      return '0;
    end
  endfunction

endpackage

FILE: hw/rtl/preferred_value_snapper_unit.sv
// Snaps a resistance in whole ohms to the nearest preferred value of an E series
// (E1, E3, E6, E12, E24, E48, E96 or E192). The result is the table mantissa in
// hundredths (100..988) and the decade exponent; a zero resistance, an unknown
// series size or one above MAX_SERIES_LEN returns valid_res low with zero fields.
// Ties go to the smaller entry, and only entries of the resistance's own decade
// are candidates. After reset the block loads its 216-entry value table into a
// one-port-read memory, one entry a cycle, and takes no request until the whole
// table is loaded. One request is worked at a time: a valid request runs the
// decade search at one step a cycle, then one table read a cycle for each entry
// of the series through a multiply, subtract and compare pipeline; an invalid
// one goes straight to the finish state. Either waits longer while the previous
// result has not yet been taken. A new request is taken while the previous
// result still waits at the output.
module preferred_value_snapper_unit #(
  parameter int MAX_SERIES_LEN = 192,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pvs_pkg::RES_W-1:0]        in_resistance_ohms,
  input  logic [pvs_pkg::SER_W-1:0]        in_series_size,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_valid_res,
  output logic [pvs_pkg::HUND_W-1:0]       out_nearest_hundredths,
  output logic [pvs_pkg::EXP_W-1:0]        out_decade_exponent
);

  import pvs_pkg::*;

  localparam int RW = (VALUE_WIDTH < RES_W) ? VALUE_WIDTH : RES_W;
  localparam int SW = RW + 4;
  localparam int PW = RW + HUND_W;
  localparam int CW = $clog2(MAX_SERIES_LEN + 1);
  localparam logic [SER_W:0] MAX_N = (SER_W+1)'(MAX_SERIES_LEN);

  state_t state_r, state_nxt;

  logic [TBL_ADDR_W-1:0] fill_addr_r, fill_addr_nxt;
  logic [RW-1:0]         r_r, r_nxt;
  logic [PW-1:0]         target_r, target_nxt;
  logic [RW-1:0]         scale_r, scale_nxt;
  logic [EXP_W-1:0]      exp_r, exp_nxt;
  logic                  ok_r, ok_nxt;
  logic [TBL_ADDR_W-1:0] addr_r, addr_nxt;
  logic [STRIDE_W-1:0]   stride_r, stride_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  logic                  rd_vld_r, rd_vld_nxt;
  logic                  prod_vld_r, prod_vld_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [HUND_W-1:0]     t1_r, t1_nxt;
  logic                  diff_vld_r, diff_vld_nxt;
  logic [PW-1:0]         diff_r, diff_nxt;
  logic [HUND_W-1:0]     t2_r, t2_nxt;
  logic                  have_r, have_nxt;
  logic [PW-1:0]         best_d_r, best_d_nxt;
  logic [HUND_W-1:0]     best_t_r, best_t_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_res_r, out_res_nxt;
  logic [HUND_W-1:0]     out_hund_r, out_hund_nxt;
  logic [EXP_W-1:0]      out_exp_r, out_exp_nxt;

  logic                  ram_we;
  logic [TBL_ADDR_W-1:0] ram_raddr;
  logic [HUND_W-1:0]     ram_rdata;

  logic [RW-1:0]         r_in;
  logic                  ser_ok;
  logic [TBL_ADDR_W-1:0] ser_base;
  logic [STRIDE_W-1:0]   ser_stride;
  logic [SW-1:0]         scale10;
  logic [PW-1:0]         prod_full;

  pvs_ram #(
    .WIDTH (HUND_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_addr_r),
    .wdata (tbl_value(fill_addr_r)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign r_in      = in_resistance_ohms[RW-1:0];
  assign scale10   = (SW'(scale_r) << 3) + (SW'(scale_r) << 1);
  assign prod_full = PW'(ram_rdata) * PW'(scale_r);
  assign ram_we    = (state_r == ST_FILL);
  assign ram_raddr = addr_r;

  // series size decode: table base and step through it
  always_comb begin
    ser_ok     = 1'b1;
    ser_base   = E24_BASE;
    ser_stride = '0;
    unique case (in_series_size)
      SER_E1:   ser_stride = 5'd24;
      SER_E3:   ser_stride = 5'd8;
      SER_E6:   ser_stride = 5'd4;
      SER_E12:  ser_stride = 5'd2;
      SER_E24:  ser_stride = 5'd1;
      SER_E48:  begin ser_base = E192_BASE; ser_stride = 5'd4; end
      SER_E96:  begin ser_base = E192_BASE; ser_stride = 5'd2; end
      SER_E192: begin ser_base = E192_BASE; ser_stride = 5'd1; end
      default:  ser_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fill_addr_nxt = fill_addr_r;
    r_nxt         = r_r;
    target_nxt    = target_r;
    scale_nxt     = scale_r;
    exp_nxt       = exp_r;
    ok_nxt        = ok_r;
    addr_nxt      = addr_r;
    stride_nxt    = stride_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    prod_vld_nxt  = rd_vld_r;
    prod_nxt      = prod_r;
    t1_nxt        = t1_r;
    diff_vld_nxt  = prod_vld_r;
    diff_nxt      = diff_r;
    t2_nxt        = t2_r;
    have_nxt      = have_r;
    best_d_nxt    = best_d_r;
    best_t_nxt    = best_t_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_hund_nxt  = out_hund_r;
    out_exp_nxt   = out_exp_r;
    in_ready      = (state_r == ST_IDLE);

    // compare pipeline: product, distance, running minimum
    if (rd_vld_r) begin
      prod_nxt = prod_full;
      t1_nxt   = ram_rdata;
    end
    if (prod_vld_r) begin
      diff_nxt = (prod_r >= target_r) ? (prod_r - target_r) : (target_r - prod_r);
      t2_nxt   = t1_r;
    end
    if (diff_vld_r && (!have_r || diff_r < best_d_r)) begin
      have_nxt   = 1'b1;
      best_d_nxt = diff_r;
      best_t_nxt = t2_r;
    end

    unique case (state_r)
      ST_FILL: begin
        fill_addr_nxt = fill_addr_r + 1'b1;
        if (fill_addr_r == TBL_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          r_nxt      = r_in;
          target_nxt = (PW'(r_in) << 6) + (PW'(r_in) << 5) + (PW'(r_in) << 2);
          scale_nxt  = RW'(1);
          exp_nxt    = '0;
          have_nxt   = 1'b0;
          addr_nxt   = ser_base;
          stride_nxt = ser_stride;
          cnt_nxt    = in_series_size[CW-1:0];
          ok_nxt     = ser_ok && (r_in != '0) && ({1'b0, in_series_size} <= MAX_N);
          state_nxt  = ok_nxt ? ST_DECADE : ST_FINISH;
        end
      end
      ST_DECADE: begin
        if (scale10 <= SW'(r_r)) begin
          scale_nxt = scale10[RW-1:0];
          exp_nxt   = exp_r + 1'b1;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cnt_r != '0) begin
          rd_vld_nxt = 1'b1;
          addr_nxt   = addr_r + TBL_ADDR_W'(stride_r);
          cnt_nxt    = cnt_r - 1'b1;
        end else if (!rd_vld_r && !prod_vld_r && !diff_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = ok_r;
          out_hund_nxt  = ok_r ? best_t_r : '0;
          out_exp_nxt   = ok_r ? exp_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_addr_r <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      diff_vld_r  <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      prod_vld_r  <= prod_vld_nxt;
      diff_vld_r  <= diff_vld_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    target_r   <= target_nxt;
    scale_r    <= scale_nxt;
    exp_r      <= exp_nxt;
    ok_r       <= ok_nxt;
    addr_r     <= addr_nxt;
    stride_r   <= stride_nxt;
    prod_r     <= prod_nxt;
    t1_r       <= t1_nxt;
    diff_r     <= diff_nxt;
    t2_r       <= t2_nxt;
    best_d_r   <= best_d_nxt;
    best_t_r   <= best_t_nxt;
    out_res_r  <= out_res_nxt;
    out_hund_r <= out_hund_nxt;
    out_exp_r  <= out_exp_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_valid_res          = out_res_r;
  assign out_nearest_hundredths = out_hund_r;
  assign out_decade_exponent    = out_exp_r;

endmodule

FILE: hw/rtl/pvs_ram.sv
module pvs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 216
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pvs_chk.sv
module pvs_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [pvs_pkg::RES_W-1:0]  in_resistance_ohms,
  input logic [pvs_pkg::SER_W-1:0]  in_series_size,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_valid_res,
  input logic [pvs_pkg::HUND_W-1:0] out_nearest_hundredths,
  input logic [pvs_pkg::EXP_W-1:0]  out_decade_exponent
);

  import pvs_pkg::*;

  // a waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_resistance_ohms)
      && $stable(in_series_size))
    else $error("request changed while waiting");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res)
      && $stable(out_nearest_hundredths) && $stable(out_decade_exponent))
    else $error("result changed while stalled");

  // one request in flight: ready drops once a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_nearest_hundredths == '0
      && out_decade_exponent == '0)
    else $error("rejected request with non-zero fields");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_nearest_hundredths >= HUND_MIN
      && out_nearest_hundredths <= HUND_MAX && out_decade_exponent <= EXP_MAX)
    else $error("preferred value out of range");

endmodule

bind preferred_value_snapper_unit pvs_chk u_pvs_chk (.*);
